FILE: sv/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types, constants and helpers of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1s_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_CELLS  = 16;
  localparam int NUM_WORDS  = 5;
  localparam int NUM_ROUNDS = 80;
  localparam int CNT_W      = 61;

  // input opcodes carried on tuser
  localparam logic [1:0] OP_ABSORB  = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // result kinds carried on tuser
  localparam logic ST_DIGEST   = 1'b0;
  localparam logic ST_OVERFLOW = 1'b1;

  localparam logic [CNT_W-1:0] MAX_BYTES = {CNT_W{1'b1}};
  localparam logic [7:0]       PAD_MARK  = 8'h80;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] chain_t;

  localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

  // control of the schedule cell row
  typedef struct packed {
    logic shift_byte;
    logic shift_word;
  } cell_ctrl_t;

  // control and status of the round unit
  typedef struct packed {
    logic start;
    logic restart;
  } round_ctrl_t;

  typedef struct packed {
    logic run;
    logic done;
  } round_stat_t;

  // top level sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COMP = 5'b00010,
    S_PAD  = 5'b00100,
    S_EMIT = 5'b01000,
    S_OVF  = 5'b10000
  } state_t;

  function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] x);
    return {x[WORD_W-2:0], x[WORD_W-1]};
  endfunction

endpackage

FILE: sv/sha1s_cell.sv
// ----------------------------------------------------------------------------
// sha1s_cell
// One word of the block / schedule row: shifts a byte in while the block is
// filled, or takes the neighbor's word while the rounds run.
// ----------------------------------------------------------------------------
module sha1s_cell (
  input  logic                             clk,
  input  sha1s_pkg::cell_ctrl_t            ctrl,
  input  logic [7:0]                       byte_in,
  input  logic [sha1s_pkg::WORD_W-1:0]     word_in,
  output logic [sha1s_pkg::WORD_W-1:0]     word
);

  // byte shift keeps big-endian packing, word shift rolls the schedule
  always_ff @(posedge clk) begin
    if (ctrl.shift_word) begin
      word <= word_in;
    end else if (ctrl.shift_byte) begin
      word <= {word[sha1s_pkg::WORD_W-9:0], byte_in};
    end
  end

endmodule

FILE: sv/sha1s_round.sv
// ----------------------------------------------------------------------------
// sha1s_round
// Round unit: working variables a..e, round counter and chaining value.
// One round per cycle, then a registered fold into the chaining value.
// ----------------------------------------------------------------------------
module sha1s_round (
  input  logic                          clk,
  input  logic                          rst,
  input  sha1s_pkg::round_ctrl_t        ctrl,
  input  logic [sha1s_pkg::WORD_W-1:0]  w_in,
  output sha1s_pkg::round_stat_t        stat,
  output sha1s_pkg::chain_t             chain
);

  localparam int RCNT_W = $clog2(sha1s_pkg::NUM_ROUNDS);

  logic [sha1s_pkg::WORD_W-1:0] a, b, c, d, e;
  logic [RCNT_W-1:0]            rcnt;
  logic                         run;
  logic                         fold;
  logic [sha1s_pkg::WORD_W-1:0] f;
  logic [sha1s_pkg::WORD_W-1:0] k;
  logic [sha1s_pkg::WORD_W-1:0] tmp;

  // round function and constant by round range
  always_comb begin
    if (rcnt < RCNT_W'(20)) begin
      f = (b & c) | (~b & d);
      k = sha1s_pkg::K_0;
    end else if (rcnt < RCNT_W'(40)) begin
      f = b ^ c ^ d;
      k = sha1s_pkg::K_1;
    end else if (rcnt < RCNT_W'(60)) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1s_pkg::K_2;
    end else begin
      f = b ^ c ^ d;
      k = sha1s_pkg::K_3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + w_in + k;
  end

  // sequencing of one compression
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fold <= 1'b0;
      rcnt <= '0;
    end else begin
      fold <= run && (rcnt == RCNT_W'(sha1s_pkg::NUM_ROUNDS - 1));
      if (ctrl.start) begin
        run  <= 1'b1;
        rcnt <= '0;
      end else if (run) begin
        if (rcnt == RCNT_W'(sha1s_pkg::NUM_ROUNDS - 1)) begin
          run <= 1'b0;
        end
        rcnt <= rcnt + 1'b1;
      end
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (run) begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      chain <= sha1s_pkg::H_INIT;
    end else if (fold) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  assign stat.run  = run;
  assign stat.done = fold;

endmodule

FILE: sv/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream with padding, length field and digest output.
// ----------------------------------------------------------------------------
// Absorb items are taken one per cycle while the hasher is idle and shifted
// into a row of sixteen 32-bit cells that hold the block; the 64th byte of
// a block starts the compression, which runs one round per cycle while the
// same row rolls the message schedule. The input is held off after that
// byte until the 80 rounds and the fold into the chaining value are done.
// A finish item feeds the padding and length bytes one per cycle through
// the same row (up to 72 bytes and one or two compressions), then five
// digest words leave at one per cycle while the output is taken. A repeated
// finish re-emits the digest at once. Input tuser is the opcode (absorb,
// finish, restart); output tuser flags the length overflow result.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_tlast,
  output logic        m_tuser    // [0] status
);

  localparam int NC = sha1s_pkg::NUM_CELLS;
  localparam int WW = sha1s_pkg::WORD_W;

  sha1s_pkg::state_t      state;
  sha1s_pkg::cell_ctrl_t  cell_ctrl;
  sha1s_pkg::round_ctrl_t rctrl;
  sha1s_pkg::round_stat_t rstat;
  sha1s_pkg::chain_t      chain;

  logic [NC-1:0][WW-1:0]          cw;
  logic [WW-1:0]                  w_new;
  logic [sha1s_pkg::CNT_W-1:0]    byte_count;
  logic [sha1s_pkg::CNT_W-1:0]    count_base;
  logic                           finished;
  logic [5:0]                     pad_off;
  logic                           pad_first;
  logic                           pad_mode;
  logic                           len_ok;
  logic                           fin_last;
  logic [2:0]                     idx;
  logic [63:0]                    len_bits;
  logic [7:0]                     pad_byte;
  logic [7:0]                     byte_in;
  logic                           accept;
  logic                           is_absorb;
  logic                           is_finish;
  logic                           is_restart;
  logic                           ovf;
  logic                           take_byte;
  logic                           out_load;
  logic                           in_pad;

  // input decode
  always_comb begin
    accept     = s_tvalid && s_tready;
    is_absorb  = accept && (s_tuser == sha1s_pkg::OP_ABSORB);
    is_finish  = accept && (s_tuser == sha1s_pkg::OP_FINISH);
    is_restart = accept && (s_tuser == sha1s_pkg::OP_RESTART);
    count_base = finished ? '0 : byte_count;
    ovf        = is_absorb && !finished && (byte_count == sha1s_pkg::MAX_BYTES);
    take_byte  = is_absorb && !ovf;
    in_pad     = (state == sha1s_pkg::S_PAD);
    out_load   = !m_tvalid || m_tready;
  end

  // padding byte: marker, zeros, then the bit length big-endian
  always_comb begin
    len_bits = {byte_count, 3'b000};
    if (pad_first) begin
      pad_byte = sha1s_pkg::PAD_MARK;
    end else if (len_ok && (pad_off >= 6'd56)) begin
      pad_byte = len_bits[{~pad_off[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
    byte_in = in_pad ? pad_byte : s_tdata;
  end

  // row and round unit control
  always_comb begin
    cell_ctrl.shift_byte = take_byte || in_pad;
    cell_ctrl.shift_word = rstat.run;
    rctrl.start   = (take_byte && (count_base[5:0] == 6'd63))
                 || (in_pad && (pad_off == 6'd63));
    rctrl.restart = (is_absorb && finished) || is_restart;
    w_new = sha1s_pkg::rotl1(cw[13] ^ cw[8] ^ cw[2] ^ cw[0]);
  end

  // row of block / schedule cells
  for (genvar i = 0; i < NC; i++) begin : g_cell
    if (i == NC - 1) begin : g_tail
      sha1s_cell u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .byte_in (byte_in),
        .word_in (w_new),
        .word    (cw[i])
      );
    end else begin : g_body
      sha1s_cell u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .byte_in (cw[i+1][WW-1 -: 8]),
        .word_in (cw[i+1]),
        .word    (cw[i])
      );
    end
  end

  sha1s_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (rctrl),
    .w_in  (cw[0]),
    .stat  (rstat),
    .chain (chain)
  );

  assign s_tready = (state == sha1s_pkg::S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha1s_pkg::S_IDLE;
      byte_count <= '0;
      finished   <= 1'b0;
      pad_off    <= '0;
      pad_first  <= 1'b0;
      pad_mode   <= 1'b0;
      len_ok     <= 1'b0;
      fin_last   <= 1'b0;
      idx        <= '0;
    end else begin
      case (state)
        sha1s_pkg::S_IDLE: begin
          if (is_restart) begin
            byte_count <= '0;
            finished   <= 1'b0;
          end else if (ovf) begin
            state <= sha1s_pkg::S_OVF;
          end else if (take_byte) begin
            byte_count <= count_base + 1'b1;
            finished   <= 1'b0;
            pad_mode   <= 1'b0;
            if (count_base[5:0] == 6'd63) begin
              state <= sha1s_pkg::S_COMP;
            end
          end else if (is_finish) begin
            idx <= '0;
            if (finished) begin
              state <= sha1s_pkg::S_EMIT;
            end else begin
              state     <= sha1s_pkg::S_PAD;
              pad_off   <= byte_count[5:0];
              pad_first <= 1'b1;
              pad_mode  <= 1'b1;
              len_ok    <= 1'b0;
              fin_last  <= 1'b0;
            end
          end
        end
        sha1s_pkg::S_PAD: begin
          pad_first <= 1'b0;
          pad_off   <= pad_off + 1'b1;
          if (pad_first && (pad_off < 6'd56)) begin
            len_ok <= 1'b1;
          end
          if (pad_off == 6'd63) begin
            fin_last <= !pad_first && len_ok;
            state    <= sha1s_pkg::S_COMP;
          end
        end
        sha1s_pkg::S_COMP: begin
          if (rstat.done) begin
            if (!pad_mode) begin
              state <= sha1s_pkg::S_IDLE;
            end else if (fin_last) begin
              state    <= sha1s_pkg::S_EMIT;
              finished <= 1'b1;
              pad_mode <= 1'b0;
              idx      <= '0;
            end else begin
              len_ok <= 1'b1;
              state  <= sha1s_pkg::S_PAD;
            end
          end
        end
        sha1s_pkg::S_EMIT: begin
          if (out_load) begin
            idx <= idx + 1'b1;
            if (idx == 3'(sha1s_pkg::NUM_WORDS - 1)) begin
              state <= sha1s_pkg::S_IDLE;
            end
          end
        end
        sha1s_pkg::S_OVF: begin
          if (out_load) begin
            state <= sha1s_pkg::S_IDLE;
          end
        end
        default: begin
          state <= sha1s_pkg::S_IDLE;
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= (state == sha1s_pkg::S_EMIT) || (state == sha1s_pkg::S_OVF);
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == sha1s_pkg::S_OVF) begin
        m_tdata <= '0;
        m_tlast <= 1'b1;
        m_tuser <= sha1s_pkg::ST_OVERFLOW;
      end else begin
        m_tdata <= {5'b00000, idx, chain[idx]};
        m_tlast <= (idx == 3'(sha1s_pkg::NUM_WORDS - 1));
        m_tuser <= sha1s_pkg::ST_DIGEST;
      end
    end
  end

endmodule

FILE: sv/sha1s_checker.sv
// ----------------------------------------------------------------------------
// sha1s_checker
// Port-level checks of the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1s_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("stalled result changed");

  // overflow result is a single zero item that ends the run
  a_ovf_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 40'd0))
    else $error("malformed overflow result");

  // digest words carry a valid index, last only on the fifth
  a_digest_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[39:35] == 5'd0)
                             && (m_tlast == (m_tdata[34:32] == 3'd4))
                             && (m_tdata[34:32] <= 3'd4))
    else $error("bad digest word index");

  // the word after a non-final digest word is the next index
  a_digest_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tuser && !m_tlast ##1 m_tvalid
      |-> !m_tuser && (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
    else $error("digest words out of order");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
